@@ sv/assert_macros.svh @@
// Assertion shorthands shared by the RTL.
// Both macros use i_clk as the sampling clock and are disabled while i_rst_n is low.
// Properties passed to the macros must not contain commas.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ERW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ERW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/erw_pkg.sv @@
package erw_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_DATA_BYTES = 64;
    localparam int DEF_ADDRESS_BITS   = 16;

    // Input modes.
    localparam logic [2:0] MODE_SCAN_START  = 3'd0;
    localparam logic [2:0] MODE_SCAN_SIG    = 3'd1;
    localparam logic [2:0] MODE_LOAD_BYTE   = 3'd2;
    localparam logic [2:0] MODE_WRITE_START = 3'd3;
    localparam logic [2:0] MODE_READY_TICK  = 3'd4;
    localparam logic [2:0] MODE_READ_ADDR   = 3'd5;

    // Memory commands.
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Slot signatures.
    localparam logic [7:0] SIG_CURRENT = 8'hAA;
    localparam logic [7:0] SIG_STALE   = 8'h55;

    // Phase codes. PHASE_SCAN together with busy marks a running scan.
    localparam logic [1:0] PHASE_DATA  = 2'd0;
    localparam logic [1:0] PHASE_SIG   = 2'd1;
    localparam logic [1:0] PHASE_STALE = 2'd2;
    localparam logic [1:0] PHASE_SCAN  = 2'd3;

    // Configuration register indexes.
    localparam int         CFG_ADDR_BITS    = 1;
    localparam logic [0:0] CFG_DATA_BYTES   = 1'd0;
    localparam logic [0:0] CFG_LAST_ADDRESS = 1'd1;

    localparam logic [6:0]  RST_DATA_BYTES   = 7'd16;
    localparam logic [15:0] RST_LAST_ADDRESS = 16'd1023;

    typedef struct packed {
        logic [2:0] mode;
        logic [5:0] index;
        logic [7:0] value;
    } t_item;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] command_address;
        logic [7:0]  command_data;
        logic        status;
        logic        done_res;
        logic        record_valid;
    } t_result;

    function automatic int idx_bits(int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

@@ sv/erw_ram.sv @@
module erw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read at the address being written returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/erw_core.sv @@
module erw_core #(
    parameter int MAX_DATA_BYTES = 64,
    parameter int ADDRESS_BITS   = 16
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_step,
    input  erw_pkg::t_item                                     i_item,
    input  logic [6:0]                                         i_data_bytes,
    input  logic [15:0]                                        i_last_address,
    input  logic [7:0]                                         i_buf_byte,
    output erw_pkg::t_result                                   o_result,
    output logic                                               o_buf_we,
    output logic [erw_pkg::idx_bits(MAX_DATA_BYTES)-1:0]       o_buf_waddr,
    output logic [erw_pkg::idx_bits(MAX_DATA_BYTES)-1:0]       o_next_offset
);
    import erw_pkg::*;

    localparam int AB = ADDRESS_BITS;
    localparam int SW = ADDRESS_BITS + 9;
    localparam int IW = idx_bits(MAX_DATA_BYTES);
    localparam logic [15:0] ADDR_MAX = 16'((32'd1 << ADDRESS_BITS) - 1);

    logic [AB-1:0] r_cur, n_cur;
    logic [AB-1:0] r_probe, n_probe;
    logic [AB-1:0] r_ws, n_ws;
    logic [AB-1:0] r_wp, n_wp;
    logic          r_known, n_known;
    logic [1:0]    r_phase, n_phase;
    logic          r_busy, n_busy;

    logic [AB-1:0] eff_last;
    logic [SW-1:0] eff_w, slot_w;
    logic [SW-1:0] cur_next, probe_next, fill, read_addr;
    logic          cur_fits, probe_fits, fill_done;
    logic          scanning, writing, idx_ok, start_ok;
    logic [AB-1:0] start;
    t_result       res;

    assign eff_last = (i_last_address > ADDR_MAX) ? ADDR_MAX[AB-1:0] : i_last_address[AB-1:0];
    assign eff_w    = SW'(eff_last);
    assign slot_w   = SW'(i_data_bytes) + SW'(1);

    // A slot at address a fits when a + S - 1 <= last address.
    assign cur_next   = SW'(r_cur) + slot_w;
    assign cur_fits   = (cur_next + slot_w - SW'(1)) <= eff_w;
    assign probe_next = SW'(r_probe) + slot_w;
    assign probe_fits = (probe_next + slot_w - SW'(1)) <= eff_w;

    assign fill      = SW'(AB'(r_wp - r_ws));
    assign fill_done = fill == SW'(i_data_bytes);
    assign read_addr = SW'(r_cur) + SW'(i_item.index) + SW'(1);

    assign scanning = r_busy && (r_phase == PHASE_SCAN);
    assign writing  = r_busy && (r_phase != PHASE_SCAN);
    assign idx_ok   = 32'(i_item.index) < MAX_DATA_BYTES;
    assign start_ok = (i_data_bytes != 7'd0) && (32'(i_data_bytes) <= MAX_DATA_BYTES)
                      && (slot_w <= eff_w);
    assign start    = (r_known && cur_fits) ? AB'(cur_next) : '0;

    always_comb begin
        n_cur    = r_cur;
        n_probe  = r_probe;
        n_ws     = r_ws;
        n_wp     = r_wp;
        n_known  = r_known;
        n_phase  = r_phase;
        n_busy   = r_busy;
        o_buf_we = 1'b0;
        res      = '{command: CMD_NONE, command_address: 16'd0, command_data: 8'd0,
                     status: 1'b1, done_res: 1'b0, record_valid: 1'b0};
        if (i_step) begin
            unique case (i_item.mode)
                MODE_SCAN_START: begin
                    if (!writing) begin
                        n_busy      = 1'b1;
                        n_phase     = PHASE_SCAN;
                        n_probe     = '0;
                        n_known     = 1'b0;
                        res.command = CMD_READ;
                        res.status  = 1'b0;
                    end
                end
                MODE_SCAN_SIG: begin
                    if (scanning) begin
                        if (i_item.value == SIG_CURRENT) begin
                            n_cur        = r_probe;
                            n_known      = 1'b1;
                            n_busy       = 1'b0;
                            n_phase      = PHASE_DATA;
                            res.status   = 1'b0;
                            res.done_res = 1'b1;
                        end else if (i_item.value == SIG_STALE && probe_fits) begin
                            n_probe             = AB'(probe_next);
                            res.command         = CMD_READ;
                            res.command_address = 16'(probe_next);
                            res.status          = 1'b0;
                        end else begin
                            n_known      = 1'b0;
                            n_busy       = 1'b0;
                            n_phase      = PHASE_DATA;
                            res.done_res = 1'b1;
                        end
                    end
                end
                MODE_LOAD_BYTE: begin
                    if (!r_busy && idx_ok) begin
                        o_buf_we   = 1'b1;
                        res.status = 1'b0;
                    end
                end
                MODE_WRITE_START: begin
                    if (!r_busy && start_ok) begin
                        n_ws                = start;
                        n_wp                = start + AB'(1);
                        n_phase             = PHASE_DATA;
                        n_busy              = 1'b1;
                        res.command         = CMD_WRITE;
                        res.command_address = 16'(start + AB'(1));
                        res.command_data    = i_buf_byte;
                        res.status          = 1'b0;
                    end
                end
                MODE_READY_TICK: begin
                    if (writing) begin
                        res.status = 1'b0;
                        if (fill_done) begin
                            if (r_phase == PHASE_DATA) begin
                                n_phase             = PHASE_SIG;
                                res.command         = CMD_WRITE;
                                res.command_address = 16'(r_ws);
                                res.command_data    = SIG_CURRENT;
                            end else if (r_phase == PHASE_SIG && r_known) begin
                                n_phase             = PHASE_STALE;
                                res.command         = CMD_WRITE;
                                res.command_address = 16'(r_cur);
                                res.command_data    = SIG_STALE;
                            end else begin
                                n_cur        = r_ws;
                                n_known      = 1'b1;
                                n_busy       = 1'b0;
                                n_phase      = PHASE_DATA;
                                res.done_res = 1'b1;
                            end
                        end else begin
                            n_wp                = r_wp + AB'(1);
                            res.command         = CMD_WRITE;
                            res.command_address = 16'(r_wp + AB'(1));
                            res.command_data    = i_buf_byte;
                        end
                    end
                end
                MODE_READ_ADDR: begin
                    if (!r_busy && r_known && ({1'b0, i_item.index} < i_data_bytes)) begin
                        res.command         = CMD_READ;
                        res.command_address = 16'(read_addr);
                        res.status          = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
        res.record_valid = n_known;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_probe <= '0;
            r_ws    <= '0;
            r_wp    <= '0;
            r_known <= 1'b0;
            r_phase <= PHASE_DATA;
            r_busy  <= 1'b0;
        end else begin
            r_cur   <= n_cur;
            r_probe <= n_probe;
            r_ws    <= n_ws;
            r_wp    <= n_wp;
            r_known <= n_known;
            r_phase <= n_phase;
            r_busy  <= n_busy;
        end
    end

    assign o_result      = res;
    assign o_buf_waddr   = IW'(i_item.index);
    // Buffer offset that the next ready tick will send, taken from the state
    // as it stands after this step.
    assign o_next_offset = IW'(AB'(n_wp - n_ws));

endmodule

@@ sv/eeprom_record_ring_writer.sv @@
// Wear-leveling record ring writer.
// Items enter on the input channel (i_in_valid / o_in_ready with i_mode, i_index,
// i_value) and every item produces exactly one result transfer on the output channel
// (o_out_valid / i_out_ready with the command fields, status, done and record flags).
// Each item is registered on entry, evaluated combinationally against the ring state,
// and the result is registered: a result passes through the input register and the
// result register; one item per cycle is sustained while the receiver keeps taking
// results. The packet buffer is a small RAM with registered read; its read is launched
// when an item is taken, so a data byte is ready when the item is evaluated.
// When the receiver stalls, the result register holds and the input register still
// takes one more item; after that o_in_ready drops until the result is taken.
// Configuration writes (i_cfg_we, i_cfg_addr, i_cfg_wdata) take effect at once and
// are expected only while the block is idle.
// Reset clears the ring state (no known record, no scan or write running), empties
// both registers and loads the register defaults. The packet buffer is not cleared.
`include "assert_macros.svh"

module eeprom_record_ring_writer #(
    parameter int MAX_DATA_BYTES = erw_pkg::DEF_MAX_DATA_BYTES,
    parameter int ADDRESS_BITS   = erw_pkg::DEF_ADDRESS_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [erw_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [15:0]                       i_cfg_wdata,
    // Input channel.
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [2:0]                        i_mode,
    input  logic [5:0]                        i_index,
    input  logic [7:0]                        i_value,
    // Output channel.
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_command,
    output logic [15:0]                       o_command_address,
    output logic [7:0]                        o_command_data,
    output logic                              o_status,
    output logic                              o_done_res,
    output logic                              o_record_valid
);
    import erw_pkg::*;

    localparam int IW = idx_bits(MAX_DATA_BYTES);

    // Configuration registers.
    logic [6:0]  r_data_bytes;
    logic [15:0] r_last_address;

    // Input and result registers.
    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;

    logic    w_take;
    logic    w_step;
    t_result w_result;

    // Packet buffer signals.
    logic          w_buf_we;
    logic [IW-1:0] w_buf_waddr;
    logic [IW-1:0] w_next_offset;
    logic [IW-1:0] w_buf_raddr;
    logic [7:0]    w_ram_q;
    logic          r_byp_hit;
    logic [7:0]    r_byp_data;
    logic [7:0]    w_buf_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_bytes   <= RST_DATA_BYTES;
            r_last_address <= RST_LAST_ADDRESS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DATA_BYTES:   r_data_bytes   <= i_cfg_wdata[6:0];
                CFG_LAST_ADDRESS: r_last_address <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // An item moves from the input register into the result register whenever
    // the result register is empty or its content is taken in the same cycle.
    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;
    assign w_take     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= '{mode: i_mode, index: i_index, value: i_value};
        end
        if (w_step) begin
            r_result <= w_result;
        end
    end

    erw_core #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES),
        .ADDRESS_BITS   (ADDRESS_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_item         (r_item),
        .i_data_bytes   (r_data_bytes),
        .i_last_address (r_last_address),
        .i_buf_byte     (w_buf_byte),
        .o_result       (w_result),
        .o_buf_we       (w_buf_we),
        .o_buf_waddr    (w_buf_waddr),
        .o_next_offset  (w_next_offset)
    );

    // A write start sends buffer byte 0; a ready tick sends the byte at the
    // offset the write pointer reaches. The read uses the state left by the
    // item being evaluated in the same cycle.
    assign w_buf_raddr = (i_mode == MODE_WRITE_START) ? '0 : w_next_offset;

    erw_ram #(
        .WIDTH (8),
        .DEPTH (MAX_DATA_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_buf_we),
        .i_waddr (w_buf_waddr),
        .i_wdata (r_item.value),
        .i_re    (w_take),
        .i_raddr (w_buf_raddr),
        .o_rdata (w_ram_q)
    );

    // The RAM returns the old byte when a load and a read meet at one address
    // in the same cycle, so the freshly loaded byte is forwarded here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else if (w_take) begin
            r_byp_hit <= w_buf_we && (w_buf_waddr == w_buf_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byp_data <= r_item.value;
        end
    end

    assign w_buf_byte = r_byp_hit ? r_byp_data : w_ram_q;

    assign o_out_valid       = r_out_valid;
    assign o_command         = r_result.command;
    assign o_command_address = r_result.command_address;
    assign o_command_data    = r_result.command_data;
    assign o_status          = r_result.status;
    assign o_done_res        = r_result.done_res;
    assign o_record_valid    = r_result.record_valid;

    // A rejected item never issues a memory command.
    `ERW_ASSERT_NOW(a_bad_no_command, r_out_valid && r_result.status,
        r_result.command == CMD_NONE, "rejected item carries a memory command")

    // A finished scan or write that succeeded leaves a known record.
    `ERW_ASSERT_NOW(a_done_known, r_out_valid && r_result.done_res && !r_result.status,
        r_result.record_valid, "successful completion without a known record")

    // An evaluated item always lands in the result register.
    `ERW_ASSERT_NEXT(a_step_fills_out, w_step, r_out_valid,
        "evaluated item did not reach the result register")

endmodule

@@ tb/eeprom_record_ring_writer_tb.sv @@
module eeprom_record_ring_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import erw_pkg::*;

    // The two modes the block does not define. They must be rejected.
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    // Shadow of everything the block remembers, including its configuration and packet buffer.
    typedef struct packed {
        logic [6:0]       data_bytes;
        logic [15:0]      last_address;
        logic [15:0]      current_slot;
        logic             slot_known;
        logic [16:0]      probe;
        logic [15:0]      wr_start;
        logic [15:0]      wr_ptr;
        logic [1:0]       phase;
        logic             busy;
        logic [63:0][7:0] pbuf;
    } t_ring;

    logic                     i_clk;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_we    = 1'b0;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr  = '0;
    logic [15:0]              i_cfg_wdata = '0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_ready;
    logic [2:0]               i_mode      = '0;
    logic [5:0]               i_index     = '0;
    logic [7:0]               i_value     = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [1:0]               o_command;
    logic [15:0]              o_command_address;
    logic [7:0]               o_command_data;
    logic                     o_status;
    logic                     o_done_res;
    logic                     o_record_valid;

    eeprom_record_ring_writer i_dut (.*);

    // Two copies of the ring state. The planning copy runs ahead while the stimulus is
    // built, so that sequences can follow the block (feed back signatures, tick a write
    // to its end). The checking copy advances only when the block takes a transfer.
    t_ring   plan_st;
    t_ring   check_st;
    // Byte image of the memory as the planned commands leave it; scans read it back.
    logic [7:0] ring_mem [0:65535];

    t_item   pending_q[$];
    t_result command_due_q[$];
    t_item   offered_item;
    t_result due_r;
    t_result want_r;
    t_result got_r;
    int      n_planned  = 0;
    int      n_results  = 0;
    int      errors     = 0;
    int      tx_burst   = 0;
    int      tx_gap     = 0;
    int      hold_left  = 0;
    int      rx_cycle   = 0;

    // Clock generation: a 4 ns period.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The run is ended here if the block stops making progress.
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_ring ring_after_reset();
        t_ring s;
        s              = '0;
        s.data_bytes   = RST_DATA_BYTES;
        s.last_address = RST_LAST_ADDRESS;
        return s;
    endfunction

    // Works out the single result that one item causes and advances the ring state.
    task automatic predict_command(inout t_ring s, input t_item it, output t_result r);
        int unsigned sz;
        int unsigned next_probe;
        int unsigned start;
        int unsigned off;
        logic        scanning;
        logic        writing;
        r        = '0;
        r.status = 1'b1;
        sz       = s.data_bytes + 32'd1;
        scanning = s.busy && (s.phase == PHASE_SCAN);
        writing  = s.busy && (s.phase != PHASE_SCAN);
        case (it.mode)
            MODE_SCAN_START: begin
                // A scan may restart a scan, but never interrupts a record write.
                if (!writing) begin
                    s.busy       = 1'b1;
                    s.phase      = PHASE_SCAN;
                    s.probe      = '0;
                    s.slot_known = 1'b0;
                    r.command    = CMD_READ;
                    r.status     = 1'b0;
                end
            end
            MODE_SCAN_SIG: begin
                if (scanning) begin
                    next_probe = s.probe + sz;
                    if (it.value == SIG_CURRENT) begin
                        s.current_slot = s.probe[15:0];
                        s.slot_known   = 1'b1;
                        s.busy         = 1'b0;
                        s.phase        = PHASE_DATA;
                        r.status       = 1'b0;
                        r.done_res     = 1'b1;
                    end else if (it.value == SIG_STALE &&
                                 next_probe + sz - 32'd1 <= s.last_address) begin
                        s.probe           = next_probe[16:0];
                        r.command         = CMD_READ;
                        r.command_address = next_probe[15:0];
                        r.status          = 1'b0;
                    end else begin
                        // Anything else, or a next slot past the end, means no record.
                        s.slot_known = 1'b0;
                        s.busy       = 1'b0;
                        s.phase      = PHASE_DATA;
                        r.done_res   = 1'b1;
                    end
                end
            end
            MODE_LOAD_BYTE: begin
                if (!s.busy) begin
                    s.pbuf[it.index] = it.value;
                    r.status         = 1'b0;
                end
            end
            MODE_WRITE_START: begin
                if (!s.busy && s.data_bytes != 7'd0 && s.data_bytes <= 7'd64 &&
                    sz <= s.last_address) begin
                    // Next slot after the current one, or wrap to address zero.
                    start = 0;
                    if (s.slot_known && s.current_slot + 2 * sz - 32'd1 <= s.last_address)
                        start = s.current_slot + sz;
                    s.wr_start        = start[15:0];
                    s.wr_ptr          = start[15:0] + 16'd1;
                    s.phase           = PHASE_DATA;
                    s.busy            = 1'b1;
                    r.command         = CMD_WRITE;
                    r.command_address = s.wr_ptr;
                    r.command_data    = s.pbuf[0];
                    r.status          = 1'b0;
                end
            end
            MODE_READY_TICK: begin
                if (writing) begin
                    r.status = 1'b0;
                    off      = s.wr_ptr - s.wr_start;
                    if (off == s.data_bytes) begin
                        if (s.phase == PHASE_DATA) begin
                            s.phase           = PHASE_SIG;
                            r.command         = CMD_WRITE;
                            r.command_address = s.wr_start;
                            r.command_data    = SIG_CURRENT;
                        end else if (s.phase == PHASE_SIG && s.slot_known) begin
                            s.phase           = PHASE_STALE;
                            r.command         = CMD_WRITE;
                            r.command_address = s.current_slot;
                            r.command_data    = SIG_STALE;
                        end else begin
                            s.current_slot = s.wr_start;
                            s.slot_known   = 1'b1;
                            s.busy         = 1'b0;
                            s.phase        = PHASE_DATA;
                            r.done_res     = 1'b1;
                        end
                    end else begin
                        s.wr_ptr          = s.wr_ptr + 16'd1;
                        off               = s.wr_ptr - s.wr_start - 32'd1;
                        r.command         = CMD_WRITE;
                        r.command_address = s.wr_ptr;
                        r.command_data    = (off < 64) ? s.pbuf[off[5:0]] : 8'h00;
                    end
                end
            end
            MODE_READ_ADDR: begin
                if (!s.busy && s.slot_known && it.index < s.data_bytes) begin
                    r.command         = CMD_READ;
                    r.command_address = s.current_slot + 16'd1 + it.index;
                    r.status          = 1'b0;
                end
            end
            default: begin
            end
        endcase
        r.record_valid = s.slot_known;
    endtask

    // Sender. An item is taken at each edge with valid and ready high; at that point the
    // checking copy predicts its result. Items go out in bursts with random gaps between.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_command(check_st, offered_item, due_r);
                command_due_q.push_back(due_r);
            end
            if (!i_in_valid || o_in_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    offered_item = pending_q.pop_front();
                    i_in_valid   <= 1'b1;
                    i_mode       <= offered_item.mode;
                    i_index      <= offered_item.index;
                    i_value      <= offered_item.value;
                    if (tx_burst > 0) begin
                        tx_burst--;
                    end else begin
                        // Some bursts run straight into the next one with no gap.
                        tx_burst = $urandom_range(0, 40);
                        tx_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Receiver. Each result transfer is checked against the oldest pending prediction.
    // The ready pattern changes in turn: always ready, coin flips, mostly ready,
    // and one cycle in four. A few times during the run the receiver holds off for a
    // long stretch so that the block backs up and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got_r.command         = o_command;
                got_r.command_address = o_command_address;
                got_r.command_data    = o_command_data;
                got_r.status          = o_status;
                got_r.done_res        = o_done_res;
                got_r.record_valid    = o_record_valid;
                if (command_due_q.size() == 0) begin
                    $display("%0t: result transfer with no prediction pending, actual %h",
                             $time, got_r);
                    errors++;
                end else begin
                    want_r = command_due_q.pop_front();
                    check_field("command", want_r.command, got_r.command);
                    check_field("command_address", want_r.command_address,
                                got_r.command_address);
                    check_field("command_data", want_r.command_data, got_r.command_data);
                    check_field("status", want_r.status, got_r.status);
                    check_field("done_res", want_r.done_res, got_r.done_res);
                    check_field("record_valid", want_r.record_valid, got_r.record_valid);
                end
                n_results++;
                if (n_results % 600 == 300)
                    hold_left = 250;
            end
            rx_cycle++;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case ((rx_cycle / 97) % 4)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 6) != 0);
                    default: i_out_ready <= (rx_cycle % 4 == 0);
                endcase
            end
        end
    end

    // Queues one item and runs it through the planning copy. Planned byte writes land in
    // the memory image so that later scans see what the block has written.
    task automatic offer(input logic [2:0] mode, input logic [5:0] index,
                         input logic [7:0] value, output t_result r);
        t_item it;
        it.mode  = mode;
        it.index = index;
        it.value = value;
        pending_q.push_back(it);
        predict_command(plan_st, it, r);
        if (r.command == CMD_WRITE)
            ring_mem[r.command_address] = r.command_data;
        n_planned++;
    endtask

    // One random item of any mode, reserved modes included.
    task automatic offer_noise();
        t_result r;
        offer(3'($urandom_range(0, 7)), 6'($urandom), 8'($urandom), r);
    endtask

    // A record update: up to four fresh data bytes, a write start, then ready ticks until the
    // write has finished. A noisy update slips random items in between the ticks.
    task automatic record_write(input bit noisy);
        t_result r;
        int      n_loads;
        int      guard;
        int      db;
        db      = plan_st.data_bytes;
        n_loads = $urandom_range(0, 4);
        for (int k = 0; k < n_loads; k++) begin
            if (db >= 1 && db <= 64)
                offer(MODE_LOAD_BYTE, 6'($urandom_range(0, db - 1)), 8'($urandom), r);
            else
                offer(MODE_LOAD_BYTE, 6'($urandom_range(0, 63)), 8'($urandom), r);
        end
        offer(MODE_WRITE_START, 6'($urandom), 8'($urandom), r);
        guard = 0;
        while (plan_st.busy && plan_st.phase != PHASE_SCAN && guard < 200) begin
            if (noisy && $urandom_range(0, 7) == 0)
                offer_noise();
            else
                offer(MODE_READY_TICK, 6'($urandom), 8'($urandom), r);
            guard++;
        end
    endtask

    // A scan that reads signatures back from the memory image, with the odd garbled
    // byte and the odd restart mixed in.
    task automatic scan_ring();
        t_result r;
        int      guard;
        offer(MODE_SCAN_START, 6'($urandom), 8'($urandom), r);
        guard = 0;
        while (plan_st.busy && plan_st.phase == PHASE_SCAN && guard < 2000) begin
            case ($urandom_range(0, 24))
                0: offer(MODE_SCAN_SIG, 6'($urandom), 8'($urandom), r);
                1: offer(MODE_SCAN_START, 6'($urandom), 8'($urandom), r);
                default: offer(MODE_SCAN_SIG, 6'($urandom), ring_mem[plan_st.probe[15:0]], r);
            endcase
            guard++;
        end
    endtask

    // Random stimulus for one configuration, left with no scan or write running.
    task automatic fill_random(input int n_items);
        t_result r;
        int      first;
        int      db;
        int      n_extra;
        first = n_planned;
        while (n_planned - first < n_items) begin
            db = plan_st.data_bytes;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: record_write($urandom_range(0, 3) == 0);
                9, 10, 11, 12, 13: scan_ring();
                14, 15, 16: begin
                    n_extra = $urandom_range(1, 4);
                    for (int k = 0; k < n_extra; k++) begin
                        if (db >= 1 && $urandom_range(0, 3) != 0)
                            offer(MODE_READ_ADDR,
                                  6'($urandom_range(0, (db > 64 ? 64 : db) - 1)),
                                  8'($urandom), r);
                        else
                            offer(MODE_READ_ADDR, 6'($urandom), 8'($urandom), r);
                    end
                end
                default: begin
                    n_extra = $urandom_range(1, 3);
                    for (int k = 0; k < n_extra; k++)
                        offer_noise();
                end
            endcase
        end
        while (plan_st.busy) begin
            if (plan_st.phase == PHASE_SCAN)
                offer(MODE_SCAN_SIG, 6'($urandom), 8'h00, r);
            else
                offer(MODE_READY_TICK, 6'($urandom), 8'($urandom), r);
        end
    endtask

    // Waits at falling edges, when all driven values have settled, until every item has
    // been taken and every result has come back, then lets the pipeline run empty.
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_q.size() != 0 || i_in_valid || command_due_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_ADDR_BITS-1:0] addr, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        if (addr == CFG_DATA_BYTES) begin
            plan_st.data_bytes  = data[6:0];
            check_st.data_bytes = data[6:0];
        end else begin
            plan_st.last_address  = data;
            check_st.last_address = data;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Configurations in order: ring extremes, a wrap-heavy ring, a slot that cannot fit,
    // record sizes out of range, and one random setting at the end.
    int unsigned cfg_db [10] = '{3, 16, 7, 64, 1, 64, 0, 1, 100, 33};
    int unsigned cfg_la [10] = '{63, 1023, 63, 65535, 63, 63, 500, 65535, 4000, 200};
    int          cfg_n  [10] = '{60, 200, 220, 160, 180, 40, 40, 200, 50, 200};

    initial begin
        t_result     r;
        int unsigned db;
        int unsigned la;
        int          n_items;
        check_st = ring_after_reset();
        plan_st  = ring_after_reset();
        for (int a = 0; a < 65536; a++)
            ring_mem[a] = 8'hFF;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fill the whole packet buffer first, so no write ever sends a byte never loaded.
        for (int k = 0; k < 64; k++)
            offer(MODE_LOAD_BYTE, 6'(k), 8'($urandom), r);

        // Directed checks under the reset configuration: rejected modes and commands
        // with nothing running, a scan of erased memory that finds no record, a first
        // write without a stale mark, and reads at the edge of the record.
        offer(MODE_SPARE_LO, 6'h3F, 8'hFF, r);
        offer(MODE_SPARE_HI, 6'h00, 8'h00, r);
        offer(MODE_READY_TICK, 6'h00, 8'h00, r);
        offer(MODE_SCAN_SIG, 6'h00, SIG_CURRENT, r);
        offer(MODE_READ_ADDR, 6'h00, 8'h00, r);
        offer(MODE_SCAN_START, 6'h00, 8'h00, r);
        offer(MODE_SCAN_SIG, 6'h00, 8'hFF, r);
        record_write(1'b0);
        offer(MODE_READ_ADDR, 6'd15, 8'h00, r);
        offer(MODE_READ_ADDR, 6'd16, 8'h00, r);

        for (int p = 0; p < 11; p++) begin
            if (p < 10) begin
                db      = cfg_db[p];
                la      = cfg_la[p];
                n_items = cfg_n[p];
            end else begin
                db      = $urandom_range(1, 64);
                la      = $urandom_range(63, 65535);
                n_items = 120;
            end
            // The sender pauses here until every result of the last phase is in.
            wait_drained();
            write_cfg(CFG_DATA_BYTES, 16'(db));
            write_cfg(CFG_LAST_ADDRESS, 16'(la));
            @(negedge i_clk);
            if (p == 0) begin
                // A scan that sees only stale slots stops before the slot that would
                // run past the last address; then a write wraps to zero, and the next
                // one marks the old slot stale.
                offer(MODE_SCAN_START, 6'h00, 8'h00, r);
                while (plan_st.busy && plan_st.phase == PHASE_SCAN)
                    offer(MODE_SCAN_SIG, 6'($urandom), SIG_STALE, r);
                record_write(1'b0);
                record_write(1'b1);
                scan_ring();
            end
            fill_random(n_items);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
